// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside of reset
`define ASSERT_CLKRST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// checked at every rising edge, reset included
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/ekt_pkg.sv =====
// ----------------------------------------------------------------------------
// ekt_pkg
// token kinds, scan modes and keyword tables of the keyword tokenizer
// ----------------------------------------------------------------------------
package ekt_pkg;

    localparam int OFFSET_WIDTH_DEF  = 16;
    localparam int KEYWORD_CHARS_DEF = 5;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 6;
    localparam int START_W = 16;
    localparam int LEN_W   = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_EOF    = 6'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 6'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd2;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 6'd3;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 6'd4;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 6'd5;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 6'd6;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 6'd7;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 6'd8;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 6'd9;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 6'd10;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 6'd11;
    localparam logic [KIND_W-1:0] KIND_STAR   = 6'd12;
    localparam logic [KIND_W-1:0] KIND_CARET  = 6'd13;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 6'd14;
    localparam logic [KIND_W-1:0] KIND_EQUAL  = 6'd15;
    localparam logic [KIND_W-1:0] KIND_KW0    = 6'd16;

    // keywords, left aligned and space padded to five characters
    localparam int KW_COUNT   = 19;
    localparam int KW_MAX_LEN = 5;
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "abs  ", "cos  ", "cosec", "cot  ", "clear", "clean", "exit ",
        "graph", "hide ", "integ", "line ", "log  ", "print", "plot ",
        "sec  ", "sin  ", "show ", "tan  ", "var  "
    };
    localparam int KW_LEN [KW_COUNT] = '{
        3, 3, 5, 3, 5, 5, 4, 5, 4, 5, 4, 3, 5, 4, 3, 3, 4, 3, 3
    };

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } t_token;

    // character i of keyword k, zero past the table width
    function automatic logic [CHAR_W-1:0] kw_char(input int k, input int i);
        logic [8*KW_MAX_LEN-1:0] w;
        w = KW_TEXT[k] << (CHAR_W * i);
        return w[8*KW_MAX_LEN-1 -: CHAR_W];
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] kind;
        case (c)
            "(":     kind = KIND_LPAREN;
            ")":     kind = KIND_RPAREN;
            "{":     kind = KIND_LBRACE;
            "}":     kind = KIND_RBRACE;
            ",":     kind = KIND_COMMA;
            "-":     kind = KIND_MINUS;
            "+":     kind = KIND_PLUS;
            "/":     kind = KIND_SLASH;
            "*":     kind = KIND_STAR;
            "^":     kind = KIND_CARET;
            ";":     kind = KIND_SEMI;
            "=":     kind = KIND_EQUAL;
            default: kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

endpackage

// ===== hdl/ekt_in_if.sv =====
// ----------------------------------------------------------------------------
// ekt_in_if
// character channel: one source byte and its last flag per beat
// ----------------------------------------------------------------------------
interface ekt_in_if
    import ekt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hdl/ekt_out_if.sv =====
// ----------------------------------------------------------------------------
// ekt_out_if
// token channel: kind, start offset, length and last mark per beat
// ----------------------------------------------------------------------------
interface ekt_out_if
    import ekt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_length;
    logic               last_token;

    modport source (
        output valid, output token_kind, output token_start,
        output token_length, output last_token, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start,
        input token_length, input last_token, output ready
    );
endinterface

// ===== hdl/expression_keyword_tokenizer_top.sv =====
// output: a character's tokens are registered, shown in the cycle after its beat
// throughput: one character per cycle while each gives at most one token and
//   the output is ready; a character giving two or three tokens holds the input
//   until the three-entry result bank drains, one token per cycle while ready
// reset: synchronous active low; scan state idle, offset zero, bank empty
// ----------------------------------------------------------------------------
// expression_keyword_tokenizer_top
// character stream tokenizer for numbers, identifiers, keywords and punctuation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module expression_keyword_tokenizer_top
    import ekt_pkg::*;
#(
    parameter int OFFSET_WIDTH  = OFFSET_WIDTH_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ekt_in_if.sink        i_chr,
    ekt_out_if.source     o_tok
);

    localparam int KI_W  = $clog2(KEYWORD_CHARS);
    localparam int EXT_W = (OFFSET_WIDTH > START_W) ? OFFSET_WIDTH : START_W;

    // scan state
    t_mode                   r_mode,   n_mode;
    logic [OFFSET_WIDTH-1:0] r_off,    n_off;
    logic [OFFSET_WIDTH-1:0] r_pstart, n_pstart;
    logic [LEN_W-1:0]        r_plen,   n_plen;
    logic                    r_ended,  n_ended;
    logic [CHAR_W-1:0]       r_buf [KEYWORD_CHARS];
    logic [CHAR_W-1:0]       n_buf [KEYWORD_CHARS];

    // result bank, head in slot 0
    t_token     r_slot [3];
    t_token     n_slot [3];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    logic in_rdy;
    logic load;
    logic pop;

    function automatic logic [KIND_W-1:0] ident_kind(
        input logic [CHAR_W-1:0] b [KEYWORD_CHARS],
        input logic [LEN_W-1:0]  len
    );
        logic [KIND_W-1:0] kind;
        logic              hit;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                hit = hit && ((LEN_W'(i) >= len) || (b[i] == kw_char(k, i)));
            end
            if (hit) begin
                kind = KIND_KW0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [START_W-1:0] to_start(input logic [OFFSET_WIDTH-1:0] off);
        logic [EXT_W-1:0] w;
        w = EXT_W'(off);
        return w[START_W-1:0];
    endfunction

    assign pop    = o_tok.valid && o_tok.ready;
    assign in_rdy = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_tok.ready);
    assign load   = i_chr.valid && in_rdy;

    assign i_chr.ready        = in_rdy;
    assign o_tok.valid        = (r_cnt != 2'd0);
    assign o_tok.token_kind   = r_slot[0].kind;
    assign o_tok.token_start  = r_slot[0].start;
    assign o_tok.token_length = r_slot[0].length;
    assign o_tok.last_token   = (r_cnt == 2'd1);

    always_comb begin
        logic [CHAR_W-1:0] c;
        logic              digit;
        logic              alpha;
        logic              sep;
        logic              taken;
        c     = i_chr.char_code;
        digit = c inside {["0":"9"]};
        alpha = c inside {["a":"z"], ["A":"Z"]};
        sep   = c inside {" ", 8'h0D, 8'h0A};
        taken = 1'b0;

        n_mode   = r_mode;
        n_off    = r_off;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_ended  = r_ended;
        n_buf    = r_buf;
        n_cnt    = 2'd0;
        for (int s = 0; s < 3; s++) begin
            n_slot[s] = '0;
        end

        if (!r_ended) begin
            if (c == '0) begin
                // zero byte: flush, then eof at the zero byte's own offset
                if (r_mode != MODE_IDLE) begin
                    n_slot[n_cnt].kind   = (r_mode == MODE_IDENT) ?
                                           ident_kind(r_buf, r_plen) : KIND_NUMBER;
                    n_slot[n_cnt].start  = to_start(r_pstart);
                    n_slot[n_cnt].length = r_plen;
                    n_cnt = n_cnt + 2'd1;
                end
                n_slot[n_cnt].kind   = KIND_EOF;
                n_slot[n_cnt].start  = to_start(r_off);
                n_slot[n_cnt].length = '0;
                n_cnt   = n_cnt + 2'd1;
                n_mode  = MODE_IDLE;
                n_ended = 1'b1;
            end else begin
                case (r_mode)
                    MODE_IDENT: taken = alpha || digit;
                    MODE_INT:   taken = digit || (c == ".");
                    MODE_FRAC:  taken = digit;
                    default:    taken = 1'b0;
                endcase

                if (taken) begin
                    if ((r_mode == MODE_IDENT) && (r_plen < LEN_W'(KEYWORD_CHARS))) begin
                        n_buf[r_plen[KI_W-1:0]] = c;
                    end
                    if (r_plen != LEN_MAX) begin
                        n_plen = r_plen + 1'b1;
                    end
                    if ((r_mode == MODE_INT) && (c == ".")) begin
                        n_mode = MODE_FRAC;
                    end
                end else begin
                    if (r_mode != MODE_IDLE) begin
                        n_slot[n_cnt].kind   = (r_mode == MODE_IDENT) ?
                                               ident_kind(r_buf, r_plen) : KIND_NUMBER;
                        n_slot[n_cnt].start  = to_start(r_pstart);
                        n_slot[n_cnt].length = r_plen;
                        n_cnt = n_cnt + 2'd1;
                    end
                    n_mode = MODE_IDLE;
                    if (sep) begin
                        // separator only ends a token
                    end else if (digit || alpha) begin
                        n_mode   = digit ? MODE_INT : MODE_IDENT;
                        n_pstart = r_off;
                        n_plen   = LEN_W'(1);
                        n_buf[0] = c;
                    end else begin
                        n_slot[n_cnt].kind   = punct_kind(c);
                        n_slot[n_cnt].start  = to_start(r_off);
                        n_slot[n_cnt].length = LEN_W'(1);
                        n_cnt = n_cnt + 2'd1;
                    end
                end

                n_off = r_off + 1'b1;

                if (i_chr.last_char) begin
                    // close out whatever this character left pending
                    if (n_mode != MODE_IDLE) begin
                        n_slot[n_cnt].kind   = (n_mode == MODE_IDENT) ?
                                               ident_kind(n_buf, n_plen) : KIND_NUMBER;
                        n_slot[n_cnt].start  = to_start(n_pstart);
                        n_slot[n_cnt].length = n_plen;
                        n_cnt = n_cnt + 2'd1;
                    end
                    n_slot[n_cnt].kind   = KIND_EOF;
                    n_slot[n_cnt].start  = to_start(n_off);
                    n_slot[n_cnt].length = '0;
                    n_cnt   = n_cnt + 2'd1;
                    n_mode  = MODE_IDLE;
                    n_ended = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_off    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_ended  <= 1'b0;
        end else if (load) begin
            r_mode   <= n_mode;
            r_off    <= n_off;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_ended  <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= n_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= n_slot;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    `ASSERT_CLKRST(a_quiet_after_eof, i_clk, i_rst_n, (load && r_ended) |=> (r_cnt == 2'd0))
    `ASSERT_CLKRST(a_eof_sets_ended, i_clk, i_rst_n,
        (load && !r_ended && ((i_chr.char_code == '0) || i_chr.last_char)) |=> r_ended)
    `ASSERT_CLKRST(a_idle_when_ended, i_clk, i_rst_n, r_ended |-> (r_mode == MODE_IDLE))
    `ASSERT_CLKRST(a_pending_nonzero, i_clk, i_rst_n, (r_mode != MODE_IDLE) |-> (r_plen != '0))

endmodule
